// ===== rtl/spectral_index_pixel_classifier_core_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef SPECTRAL_INDEX_PIXEL_CLASSIFIER_CORE_MACROS_SVH
`define SPECTRAL_INDEX_PIXEL_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIPC_ASSERT_IMPLY(label, clk_sig, rst_sig, cond, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (cond) |-> (prop)) \
        else $error("sipc check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SIPC_ASSERT_NEXT(label, clk_sig, rst_sig, cond, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (cond) |=> (prop)) \
        else $error("sipc check failed");

`endif

// ===== rtl/sipc_pkg.sv =====
package sipc_pkg;

    localparam int SAMPLE_BITS_DEFAULT   = 16;
    localparam int FRACTION_BITS_DEFAULT = 14;

    localparam int INDEX_BITS     = 16;
    localparam int THRESH_BITS    = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CLASS_BITS     = 2;

    localparam logic [THRESH_BITS-1:0] VEG_THRESHOLD_RESET = 16'd4915;
    localparam logic [THRESH_BITS-1:0] WAT_THRESHOLD_RESET = 16'd0;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_VEG_THRESHOLD = 2'd0,
        CFG_WAT_THRESHOLD = 2'd1
    } cfg_reg_t;

    typedef enum logic [CLASS_BITS-1:0] {
        CLASS_NO_DATA    = 2'd0,
        CLASS_WATER      = 2'd1,
        CLASS_VEGETATION = 2'd2,
        CLASS_OTHER      = 2'd3
    } pixel_class_t;

    // Control word that walks down the divider chain with each pixel.
    typedef struct packed {
        logic valid;
        logic last;
        logic veg_nd;
        logic wat_nd;
        logic veg_neg;
        logic wat_neg;
    } sipc_ctrl_t;

endpackage

// ===== rtl/sipc_div_cell.sv =====
module sipc_div_cell #(
    parameter int SAMPLE_BITS   = sipc_pkg::SAMPLE_BITS_DEFAULT,
    parameter int FRACTION_BITS = sipc_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  sipc_pkg::sipc_ctrl_t   ctrl_in,
    input  logic [SAMPLE_BITS:0]   veg_sum_in,
    input  logic [SAMPLE_BITS:0]   veg_rem_in,
    input  logic [FRACTION_BITS:0] veg_quot_in,
    input  logic [SAMPLE_BITS:0]   wat_sum_in,
    input  logic [SAMPLE_BITS:0]   wat_rem_in,
    input  logic [FRACTION_BITS:0] wat_quot_in,
    output sipc_pkg::sipc_ctrl_t   ctrl_out,
    output logic [SAMPLE_BITS:0]   veg_sum_out,
    output logic [SAMPLE_BITS:0]   veg_rem_out,
    output logic [FRACTION_BITS:0] veg_quot_out,
    output logic [SAMPLE_BITS:0]   wat_sum_out,
    output logic [SAMPLE_BITS:0]   wat_rem_out,
    output logic [FRACTION_BITS:0] wat_quot_out
);

    localparam int SW = SAMPLE_BITS + 1;

    sipc_pkg::sipc_ctrl_t   ctrl_reg;
    logic [SW-1:0]          veg_sum_reg;
    logic [SW-1:0]          veg_rem_reg;
    logic [FRACTION_BITS:0] veg_quot_reg;
    logic [SW-1:0]          wat_sum_reg;
    logic [SW-1:0]          wat_rem_reg;
    logic [FRACTION_BITS:0] wat_quot_reg;

    logic [SW:0]            veg_dbl;
    logic [SW+1:0]          veg_diff;
    logic                   veg_fit;
    logic [SW-1:0]          veg_rem_next;
    logic [FRACTION_BITS:0] veg_quot_next;
    logic [SW:0]            wat_dbl;
    logic [SW+1:0]          wat_diff;
    logic                   wat_fit;
    logic [SW-1:0]          wat_rem_next;
    logic [FRACTION_BITS:0] wat_quot_next;

    // One restoring step: double the remainder, subtract the sum where it fits.
    always_comb
    begin
        veg_dbl       = {veg_rem_in, 1'b0};
        veg_diff      = {1'b0, veg_dbl} - {2'b00, veg_sum_in};
        veg_fit       = ~veg_diff[SW+1];
        veg_rem_next  = veg_fit ? veg_diff[SW-1:0] : veg_dbl[SW-1:0];
        veg_quot_next = {veg_quot_in[FRACTION_BITS-1:0], veg_fit};

        wat_dbl       = {wat_rem_in, 1'b0};
        wat_diff      = {1'b0, wat_dbl} - {2'b00, wat_sum_in};
        wat_fit       = ~wat_diff[SW+1];
        wat_rem_next  = wat_fit ? wat_diff[SW-1:0] : wat_dbl[SW-1:0];
        wat_quot_next = {wat_quot_in[FRACTION_BITS-1:0], wat_fit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            veg_sum_reg  <= veg_sum_in;
            veg_rem_reg  <= veg_rem_next;
            veg_quot_reg <= veg_quot_next;
            wat_sum_reg  <= wat_sum_in;
            wat_rem_reg  <= wat_rem_next;
            wat_quot_reg <= wat_quot_next;
        end
    end

    assign ctrl_out     = ctrl_reg;
    assign veg_sum_out  = veg_sum_reg;
    assign veg_rem_out  = veg_rem_reg;
    assign veg_quot_out = veg_quot_reg;
    assign wat_sum_out  = wat_sum_reg;
    assign wat_rem_out  = wat_rem_reg;
    assign wat_quot_out = wat_quot_reg;

endmodule

// ===== rtl/sipc_class.sv =====
module sipc_class #(
    parameter int FRACTION_BITS = sipc_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  sipc_pkg::sipc_ctrl_t                ctrl_in,
    input  logic [FRACTION_BITS:0]              veg_quot_in,
    input  logic [FRACTION_BITS:0]              wat_quot_in,
    input  logic [sipc_pkg::THRESH_BITS-1:0]    veg_threshold,
    input  logic [sipc_pkg::THRESH_BITS-1:0]    wat_threshold,
    output logic                                out_valid,
    output logic [sipc_pkg::INDEX_BITS-1:0]     vegetation_index,
    output logic                                vegetation_no_data,
    output logic [sipc_pkg::INDEX_BITS-1:0]     water_index,
    output logic                                water_no_data,
    output logic [sipc_pkg::CLASS_BITS-1:0]     pixel_class,
    output logic                                last_out
);

    localparam int IW = FRACTION_BITS + 2;
    localparam int CW = (IW > sipc_pkg::INDEX_BITS) ? IW : sipc_pkg::INDEX_BITS;
    localparam logic signed [IW-1:0] NO_DATA = {2'b10, {FRACTION_BITS{1'b0}}};

    logic                            out_valid_reg;
    logic [sipc_pkg::INDEX_BITS-1:0] veg_index_reg;
    logic                            veg_nd_reg;
    logic [sipc_pkg::INDEX_BITS-1:0] wat_index_reg;
    logic                            wat_nd_reg;
    sipc_pkg::pixel_class_t          class_reg;
    logic                            last_reg;

    logic signed [IW-1:0]            veg_mag;
    logic signed [IW-1:0]            wat_mag;
    logic signed [IW-1:0]            veg_idx;
    logic signed [IW-1:0]            wat_idx;
    logic signed [CW-1:0]            veg_wide;
    logic signed [CW-1:0]            wat_wide;
    logic signed [CW-1:0]            veg_thr_wide;
    logic signed [CW-1:0]            wat_thr_wide;
    sipc_pkg::pixel_class_t          class_next;

    // Apply the sign after the magnitude quotient; a zero sum takes the no-data code.
    always_comb
    begin
        veg_mag      = $signed({1'b0, veg_quot_in});
        wat_mag      = $signed({1'b0, wat_quot_in});
        veg_idx      = ctrl_in.veg_nd ? NO_DATA : (ctrl_in.veg_neg ? -veg_mag : veg_mag);
        wat_idx      = ctrl_in.wat_nd ? NO_DATA : (ctrl_in.wat_neg ? -wat_mag : wat_mag);
        veg_wide     = CW'(veg_idx);
        wat_wide     = CW'(wat_idx);
        veg_thr_wide = CW'($signed(veg_threshold));
        wat_thr_wide = CW'($signed(wat_threshold));
    end

    always_comb
    begin
        if (ctrl_in.veg_nd || ctrl_in.wat_nd)
        begin
            class_next = sipc_pkg::CLASS_NO_DATA;
        end
        else if (wat_wide > wat_thr_wide)
        begin
            class_next = sipc_pkg::CLASS_WATER;
        end
        else if (veg_wide > veg_thr_wide)
        begin
            class_next = sipc_pkg::CLASS_VEGETATION;
        end
        else
        begin
            class_next = sipc_pkg::CLASS_OTHER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctrl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            veg_index_reg <= veg_wide[sipc_pkg::INDEX_BITS-1:0];
            veg_nd_reg    <= ctrl_in.veg_nd;
            wat_index_reg <= wat_wide[sipc_pkg::INDEX_BITS-1:0];
            wat_nd_reg    <= ctrl_in.wat_nd;
            class_reg     <= class_next;
            last_reg      <= ctrl_in.last;
        end
    end

    assign out_valid          = out_valid_reg;
    assign vegetation_index   = veg_index_reg;
    assign vegetation_no_data = veg_nd_reg;
    assign water_index        = wat_index_reg;
    assign water_no_data      = wat_nd_reg;
    assign pixel_class        = class_reg;
    assign last_out           = last_reg;

endmodule

// ===== rtl/spectral_index_pixel_classifier_core.sv =====
// Spectral index pixel classifier: one pixel (green, red, near-infrared) in, one result out
// with the vegetation and water normalized-difference indices in signed Q2.FRACTION_BITS,
// their no-data flags and a four-way class. The block takes one pixel every cycle while the
// output is not stalled: an entry stage forms the
// sums and differences, a chain of FRACTION_BITS divider cells yields one quotient bit each,
// and an output stage applies the sign and classifies. A stalled output freezes the whole
// chain, so in_ready follows out_ready while a result waits. Threshold writes are taken at
// any time and apply to pixels that reach the output stage afterwards.
module spectral_index_pixel_classifier_core #(
    parameter int SAMPLE_BITS   = sipc_pkg::SAMPLE_BITS_DEFAULT,
    parameter int FRACTION_BITS = sipc_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [SAMPLE_BITS-1:0]               green_sample,
    input  logic [SAMPLE_BITS-1:0]               red_sample,
    input  logic [SAMPLE_BITS-1:0]               nir_sample,
    input  logic                                 last_pixel,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sipc_pkg::INDEX_BITS-1:0]      vegetation_index,
    output logic                                 vegetation_no_data,
    output logic [sipc_pkg::INDEX_BITS-1:0]      water_index,
    output logic                                 water_no_data,
    output logic [sipc_pkg::CLASS_BITS-1:0]      pixel_class,
    output logic                                 last_out,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sipc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sipc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int SW = SAMPLE_BITS + 1;

    logic [sipc_pkg::THRESH_BITS-1:0] veg_threshold_reg;
    logic [sipc_pkg::THRESH_BITS-1:0] wat_threshold_reg;

    sipc_pkg::sipc_ctrl_t   entry_ctrl_reg;
    logic [SW-1:0]          entry_veg_sum_reg;
    logic [SW-1:0]          entry_veg_rem_reg;
    logic [FRACTION_BITS:0] entry_veg_quot_reg;
    logic [SW-1:0]          entry_wat_sum_reg;
    logic [SW-1:0]          entry_wat_rem_reg;
    logic [FRACTION_BITS:0] entry_wat_quot_reg;

    sipc_pkg::sipc_ctrl_t   entry_ctrl_next;
    logic [SW-1:0]          veg_sum;
    logic [SW-1:0]          wat_sum;
    logic [SAMPLE_BITS-1:0] veg_mag;
    logic [SAMPLE_BITS-1:0] wat_mag;
    logic                   veg_full;
    logic                   wat_full;

    sipc_pkg::sipc_ctrl_t   ctrl_chain     [FRACTION_BITS+1];
    logic [SW-1:0]          veg_sum_chain  [FRACTION_BITS+1];
    logic [SW-1:0]          veg_rem_chain  [FRACTION_BITS+1];
    logic [FRACTION_BITS:0] veg_quot_chain [FRACTION_BITS+1];
    logic [SW-1:0]          wat_sum_chain  [FRACTION_BITS+1];
    logic [SW-1:0]          wat_rem_chain  [FRACTION_BITS+1];
    logic [FRACTION_BITS:0] wat_quot_chain [FRACTION_BITS+1];

    logic                   en;

    // Advance the chain unless a finished result is held at the output.
    assign en        = ~out_valid | out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            veg_threshold_reg <= sipc_pkg::VEG_THRESHOLD_RESET;
            wat_threshold_reg <= sipc_pkg::WAT_THRESHOLD_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sipc_pkg::CFG_VEG_THRESHOLD: veg_threshold_reg <= cfg_data;
                sipc_pkg::CFG_WAT_THRESHOLD: wat_threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The leading quotient bit is set only when one operand is zero (difference equals sum).
    always_comb
    begin
        veg_sum  = {1'b0, nir_sample} + {1'b0, red_sample};
        wat_sum  = {1'b0, green_sample} + {1'b0, nir_sample};
        veg_mag  = (nir_sample < red_sample) ? (red_sample - nir_sample)
                                             : (nir_sample - red_sample);
        wat_mag  = (green_sample < nir_sample) ? (nir_sample - green_sample)
                                               : (green_sample - nir_sample);
        veg_full = (nir_sample == '0) || (red_sample == '0);
        wat_full = (green_sample == '0) || (nir_sample == '0);

        entry_ctrl_next.valid   = in_valid;
        entry_ctrl_next.last    = last_pixel;
        entry_ctrl_next.veg_nd  = (veg_sum == '0);
        entry_ctrl_next.wat_nd  = (wat_sum == '0);
        entry_ctrl_next.veg_neg = (nir_sample < red_sample);
        entry_ctrl_next.wat_neg = (green_sample < nir_sample);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_ctrl_reg <= '0;
        end
        else if (en)
        begin
            entry_ctrl_reg <= entry_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_veg_sum_reg  <= veg_sum;
            entry_veg_rem_reg  <= veg_full ? '0 : {1'b0, veg_mag};
            entry_veg_quot_reg <= {{FRACTION_BITS{1'b0}}, veg_full};
            entry_wat_sum_reg  <= wat_sum;
            entry_wat_rem_reg  <= wat_full ? '0 : {1'b0, wat_mag};
            entry_wat_quot_reg <= {{FRACTION_BITS{1'b0}}, wat_full};
        end
    end

    assign ctrl_chain[0]     = entry_ctrl_reg;
    assign veg_sum_chain[0]  = entry_veg_sum_reg;
    assign veg_rem_chain[0]  = entry_veg_rem_reg;
    assign veg_quot_chain[0] = entry_veg_quot_reg;
    assign wat_sum_chain[0]  = entry_wat_sum_reg;
    assign wat_rem_chain[0]  = entry_wat_rem_reg;
    assign wat_quot_chain[0] = entry_wat_quot_reg;

    for (genvar i = 0; i < FRACTION_BITS; i++)
    begin : g_cell
        sipc_div_cell #(
            .SAMPLE_BITS   (SAMPLE_BITS),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .en           (en),
            .ctrl_in      (ctrl_chain[i]),
            .veg_sum_in   (veg_sum_chain[i]),
            .veg_rem_in   (veg_rem_chain[i]),
            .veg_quot_in  (veg_quot_chain[i]),
            .wat_sum_in   (wat_sum_chain[i]),
            .wat_rem_in   (wat_rem_chain[i]),
            .wat_quot_in  (wat_quot_chain[i]),
            .ctrl_out     (ctrl_chain[i+1]),
            .veg_sum_out  (veg_sum_chain[i+1]),
            .veg_rem_out  (veg_rem_chain[i+1]),
            .veg_quot_out (veg_quot_chain[i+1]),
            .wat_sum_out  (wat_sum_chain[i+1]),
            .wat_rem_out  (wat_rem_chain[i+1]),
            .wat_quot_out (wat_quot_chain[i+1])
        );
    end

    sipc_class #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_class (
        .clk                (clk),
        .rst_n              (rst_n),
        .en                 (en),
        .ctrl_in            (ctrl_chain[FRACTION_BITS]),
        .veg_quot_in        (veg_quot_chain[FRACTION_BITS]),
        .wat_quot_in        (wat_quot_chain[FRACTION_BITS]),
        .veg_threshold      (veg_threshold_reg),
        .wat_threshold      (wat_threshold_reg),
        .out_valid          (out_valid),
        .vegetation_index   (vegetation_index),
        .vegetation_no_data (vegetation_no_data),
        .water_index        (water_index),
        .water_no_data      (water_no_data),
        .pixel_class        (pixel_class),
        .last_out           (last_out)
    );

endmodule

// ===== rtl/sipc_checker.sv =====
`include "spectral_index_pixel_classifier_core_macros.svh"

module sipc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [sipc_pkg::INDEX_BITS-1:0]  vegetation_index,
    input logic                             vegetation_no_data,
    input logic [sipc_pkg::INDEX_BITS-1:0]  water_index,
    input logic                             water_no_data,
    input logic [sipc_pkg::CLASS_BITS-1:0]  pixel_class,
    input logic                             last_out
);

    // Hold a stalled result.
    `SIPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(vegetation_index) && $stable(water_index) && $stable(pixel_class) && $stable(last_out))

    // A held result stalls the input side as well.
    `SIPC_ASSERT_IMPLY(a_stall_input, clk, rst_n, out_valid && !out_ready, !in_ready)

    // The no-data class appears exactly when a sum was zero.
    `SIPC_ASSERT_IMPLY(a_class_no_data, clk, rst_n, out_valid, (pixel_class == sipc_pkg::CLASS_NO_DATA) == (vegetation_no_data || water_no_data))

endmodule

bind spectral_index_pixel_classifier_core sipc_checker u_sipc_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .vegetation_index   (vegetation_index),
    .vegetation_no_data (vegetation_no_data),
    .water_index        (water_index),
    .water_no_data      (water_no_data),
    .pixel_class        (pixel_class),
    .last_out           (last_out)
);

// ===== dv/tb_spectral_index_pixel_classifier_core.sv =====
module tb_spectral_index_pixel_classifier_core;

    localparam int SAMPLE_W       = sipc_pkg::SAMPLE_BITS_DEFAULT;
    localparam int FRAC_BITS      = sipc_pkg::FRACTION_BITS_DEFAULT;
    localparam int PHASES         = 10;
    localparam int PIXELS_PER_SET = 75;
    localparam int DRAIN_CYCLES   = 40;
    localparam int STALL_LIMIT    = 2000;

    // -2.0 in Q2.14, masked to the index field
    localparam logic [sipc_pkg::INDEX_BITS-1:0] NO_DATA_CODE = 16'h8000;

    // register indexes with no register behind them
    localparam logic [sipc_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [sipc_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] nir;
        logic                last;
    } pixel_t;

    typedef struct packed {
        logic [sipc_pkg::INDEX_BITS-1:0] veg;
        logic                            veg_nd;
        logic [sipc_pkg::INDEX_BITS-1:0] wat;
        logic                            wat_nd;
        sipc_pkg::pixel_class_t          cls;
        logic                            last;
    } pixel_result_t;

    typedef struct {
        pixel_t      px;
        int unsigned gap;
    } queued_pixel_t;

    logic                                clk;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic [SAMPLE_W-1:0]                 green_sample = '0;
    logic [SAMPLE_W-1:0]                 red_sample = '0;
    logic [SAMPLE_W-1:0]                 nir_sample = '0;
    logic                                last_pixel = 1'b0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [sipc_pkg::INDEX_BITS-1:0]     vegetation_index;
    logic                                vegetation_no_data;
    logic [sipc_pkg::INDEX_BITS-1:0]     water_index;
    logic                                water_no_data;
    logic [sipc_pkg::CLASS_BITS-1:0]     pixel_class;
    logic                                last_out;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [sipc_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [sipc_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    // thresholds as the block should hold them
    logic [sipc_pkg::THRESH_BITS-1:0] veg_level = sipc_pkg::VEG_THRESHOLD_RESET;
    logic [sipc_pkg::THRESH_BITS-1:0] wat_level = sipc_pkg::WAT_THRESHOLD_RESET;

    queued_pixel_t pixel_queue[$];
    pixel_result_t predicted_results[$];

    bit in_took;
    bit out_took;
    bit cfg_took;
    bit send_steady;
    bit recv_steady;
    int unsigned pixels_queued;
    int unsigned pixels_taken;
    int unsigned results_checked;
    int unsigned reg_writes;
    int unsigned errors;
    int unsigned stall_cycles;
    int unsigned class_seen[4];

    spectral_index_pixel_classifier_core dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .green_sample       (green_sample),
        .red_sample         (red_sample),
        .nir_sample         (nir_sample),
        .last_pixel         (last_pixel),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .vegetation_index   (vegetation_index),
        .vegetation_no_data (vegetation_no_data),
        .water_index        (water_index),
        .water_no_data      (water_no_data),
        .pixel_class        (pixel_class),
        .last_out           (last_out),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // (a - b) / (a + b) in Q2.14, magnitude truncated, sign applied afterwards
    function automatic logic [sipc_pkg::INDEX_BITS-1:0] normalized_difference(
        logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
        logic [SAMPLE_W:0] total;
        logic [29:0]       scaled;
        logic [29:0]       quotient;
        total    = {1'b0, a} + {1'b0, b};
        scaled   = 30'((a >= b) ? (a - b) : (b - a));
        scaled   = scaled << FRAC_BITS;
        quotient = scaled / 30'(total);
        if (a >= b)
            return quotient[sipc_pkg::INDEX_BITS-1:0];
        return -quotient[sipc_pkg::INDEX_BITS-1:0];
    endfunction

    function automatic pixel_result_t predict_pixel(pixel_t px);
        pixel_result_t     r;
        logic [SAMPLE_W:0] veg_sum;
        logic [SAMPLE_W:0] wat_sum;
        veg_sum  = {1'b0, px.nir} + {1'b0, px.red};
        wat_sum  = {1'b0, px.green} + {1'b0, px.nir};
        r.veg_nd = (veg_sum == '0);
        r.wat_nd = (wat_sum == '0);
        r.veg    = r.veg_nd ? NO_DATA_CODE : normalized_difference(px.nir, px.red);
        r.wat    = r.wat_nd ? NO_DATA_CODE : normalized_difference(px.green, px.nir);
        if (r.veg_nd || r.wat_nd)
            r.cls = sipc_pkg::CLASS_NO_DATA;
        else if ($signed(r.wat) > $signed(wat_level))
            r.cls = sipc_pkg::CLASS_WATER;
        else if ($signed(r.veg) > $signed(veg_level))
            r.cls = sipc_pkg::CLASS_VEGETATION;
        else
            r.cls = sipc_pkg::CLASS_OTHER;
        r.last = px.last;
        return r;
    endfunction

    task automatic check_field(string field, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // Handshake bookkeeping, prediction on input, comparison on output, stall watchdog.
    always @(posedge clk)
    begin
        pixel_t        px;
        pixel_result_t want;
        in_took  = rst_n && in_valid && in_ready;
        out_took = rst_n && out_valid && out_ready;
        cfg_took = rst_n && cfg_valid && cfg_ready;
        if (in_took)
        begin
            px = '{green: green_sample, red: red_sample, nir: nir_sample, last: last_pixel};
            predicted_results.push_back(predict_pixel(px));
            pixels_taken++;
        end
        if (cfg_took)
        begin
            reg_writes++;
            case (cfg_index)
                sipc_pkg::CFG_VEG_THRESHOLD: veg_level = cfg_data;
                sipc_pkg::CFG_WAT_THRESHOLD: wat_level = cfg_data;
                default: ;
            endcase
        end
        if (out_took)
        begin
            if (predicted_results.size() == 0)
            begin
                errors++;
                $display("%0t: result transaction with no pixel outstanding", $time);
            end
            else
            begin
                want = predicted_results.pop_front();
                results_checked++;
                class_seen[want.cls]++;
                check_field("vegetation_index", int'($signed(want.veg)),
                            int'($signed(vegetation_index)));
                check_field("vegetation_no_data", int'(want.veg_nd),
                            int'(vegetation_no_data));
                check_field("water_index", int'($signed(want.wat)),
                            int'($signed(water_index)));
                check_field("water_no_data", int'(want.wat_nd), int'(water_no_data));
                check_field("pixel_class", int'(want.cls), int'(pixel_class));
                check_field("last_out", int'(want.last), int'(last_out));
            end
        end
        if (in_took || out_took || cfg_took || !rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Pixel driver: hold the payload until taken, idle for the drawn gap before each pixel.
    always @(negedge clk)
    begin
        static queued_pixel_t staged;
        static bit            have_staged = 1'b0;
        if (!(in_valid && !in_took))
        begin
            if (!have_staged && pixel_queue.size() > 0)
            begin
                staged      = pixel_queue.pop_front();
                have_staged = 1'b1;
            end
            if (have_staged && staged.gap == 0)
            begin
                green_sample <= staged.px.green;
                red_sample   <= staged.px.red;
                nir_sample   <= staged.px.nir;
                last_pixel   <= staged.px.last;
                in_valid     <= 1'b1;
                have_staged  = 1'b0;
            end
            else
            begin
                in_valid <= 1'b0;
                if (have_staged)
                    staged.gap--;
            end
        end
    end

    // Result side: after each result transaction, stall for a fresh random count unless recv_steady is set.
    always @(negedge clk)
    begin
        static int unsigned ready_hold = 0;
        if (out_took)
            ready_hold = recv_steady ? 0 : $urandom_range(0, 13);
        if (ready_hold > 0)
        begin
            ready_hold--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic queue_pixel(pixel_t px);
        queued_pixel_t entry;
        entry.px  = px;
        entry.gap = send_steady ? 0 : $urandom_range(0, 13);
        pixel_queue.push_back(entry);
        pixels_queued++;
    endtask

    task automatic queue_sample(logic [SAMPLE_W-1:0] g, logic [SAMPLE_W-1:0] r,
                                logic [SAMPLE_W-1:0] n, logic l);
        queue_pixel('{green: g, red: r, nir: n, last: l});
    endtask

    function automatic pixel_t random_pixel();
        pixel_t      px;
        int unsigned base;
        px.green = SAMPLE_W'($urandom_range(0, 65535));
        px.red   = SAMPLE_W'($urandom_range(0, 65535));
        px.nir   = SAMPLE_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 5))
            2:
            begin
                // tiny samples: zero sums and equal bands turn up often
                px.green = SAMPLE_W'($urandom_range(0, 3));
                px.red   = SAMPLE_W'($urandom_range(0, 3));
                px.nir   = SAMPLE_W'($urandom_range(0, 3));
            end
            3:
            begin
                base     = $urandom_range(0, 65535 - 63);
                px.green = SAMPLE_W'(base + $urandom_range(0, 63));
                px.red   = SAMPLE_W'(base + $urandom_range(0, 63));
                px.nir   = SAMPLE_W'(base + $urandom_range(0, 63));
            end
            4:
            begin
                if ($urandom_range(0, 1))
                    px.green = '0;
                if ($urandom_range(0, 1))
                    px.red = '0;
                if ($urandom_range(0, 1))
                    px.nir = '0;
            end
            5:
            begin
                px.green = px.green >> $urandom_range(0, 15);
                px.red   = px.red >> $urandom_range(0, 15);
                px.nir   = px.nir >> $urandom_range(0, 15);
            end
            default: ;
        endcase
        px.last = ($urandom_range(0, 7) == 0);
        return px;
    endfunction

    function automatic logic [sipc_pkg::THRESH_BITS-1:0] random_threshold(bit any_pattern);
        int level;
        if (any_pattern)
            return sipc_pkg::THRESH_BITS'($urandom_range(0, 65535));
        level = int'($urandom_range(0, 32768)) - 16384;
        return level[sipc_pkg::THRESH_BITS-1:0];
    endfunction

    task automatic write_reg(logic [sipc_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [sipc_pkg::CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_took)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every queued pixel has been taken and every result checked.
    task automatic wait_drained();
        @(negedge clk);
        while (pixels_taken != pixels_queued || predicted_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [sipc_pkg::THRESH_BITS-1:0] veg_settings[PHASES];
        logic [sipc_pkg::THRESH_BITS-1:0] wat_settings[PHASES];
        send_steady = 1'b0;
        recv_steady = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // reset thresholds: corners, truncation, ties at the thresholds
        queue_sample(16'h0000, 16'h0000, 16'h0000, 1'b0);
        queue_sample(16'h0000, 16'h0005, 16'h0000, 1'b0);
        queue_sample(16'h0007, 16'h0000, 16'h0000, 1'b1);
        queue_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_sample(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
        queue_sample(16'hFFFF, 16'h0001, 16'h0000, 1'b0);
        queue_sample(16'h0001, 16'hFFFF, 16'hFFFF, 1'b1);
        queue_sample(16'h0000, 16'h0002, 16'h0001, 1'b0);
        queue_sample(16'h0002, 16'h0000, 16'h0001, 1'b0);
        queue_sample(16'd100, 16'd0, 16'd100, 1'b0);
        queue_sample(16'd100, 16'd100, 16'd100, 1'b0);
        queue_sample(16'h0000, 16'h0000, 16'h0001, 1'b0);
        queue_sample(16'h0001, 16'h0000, 16'h0000, 1'b0);
        queue_sample(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
        queue_sample(16'h8000, 16'h7FFF, 16'h8000, 1'b1);
        queue_sample(16'd21299, 16'd11469, 16'd21299, 1'b0);
        queue_sample(16'd21301, 16'd11467, 16'd21301, 1'b0);
        queue_sample(16'd1001, 16'd0, 16'd1000, 1'b0);
        queue_sample(16'h5555, 16'hAAAA, 16'h5555, 1'b0);
        queue_sample(16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
        wait_drained();

        veg_settings = '{16'd16384, 16'hC000, 16'h8000, 16'h7FFF, 16'd0,
                         16'd0, 16'd0, 16'd0, 16'd0, sipc_pkg::VEG_THRESHOLD_RESET};
        wat_settings = '{16'd16384, 16'hC000, 16'h7FFF, 16'h8000, 16'd0,
                         16'd0, 16'd0, 16'd0, 16'd0, sipc_pkg::WAT_THRESHOLD_RESET};
        for (int p = 5; p < 9; p++)
        begin
            veg_settings[p] = random_threshold(p == 7);
            wat_settings[p] = random_threshold(p == 7);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(sipc_pkg::CFG_VEG_THRESHOLD, veg_settings[p]);
            write_reg(sipc_pkg::CFG_WAT_THRESHOLD, wat_settings[p]);
            // writes to unmapped indexes must leave both thresholds alone
            if (p < 2 || $urandom_range(0, 1))
                write_reg(p[0] ? CFG_SPARE_3 : CFG_SPARE_2,
                          sipc_pkg::CFG_DATA_BITS'($urandom_range(0, 65535)));
            send_steady = (p % 4 == 1) || (p % 4 == 3);
            recv_steady = (p % 4 == 2) || (p % 4 == 3);
            for (int i = 0; i < PIXELS_PER_SET; i++)
                queue_pixel(random_pixel());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Checked %0d results from %0d pixels across %0d threshold sets, %0d reg writes",
                 results_checked, pixels_taken, PHASES + 1, reg_writes);
        $display("Class mix: no data %0d, water %0d, vegetation %0d, other %0d",
                 class_seen[sipc_pkg::CLASS_NO_DATA], class_seen[sipc_pkg::CLASS_WATER],
                 class_seen[sipc_pkg::CLASS_VEGETATION], class_seen[sipc_pkg::CLASS_OTHER]);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sipc_pkg.sv
rtl/sipc_div_cell.sv
rtl/sipc_class.sv
rtl/spectral_index_pixel_classifier_core.sv
rtl/sipc_checker.sv
dv/tb_spectral_index_pixel_classifier_core.sv
